[sv/priority_rr_task_scheduler_defines.svh]
// Assertion macros shared by the scheduler's checker.
// Depends on nothing; the macros expect clk_i and rst_ni in the using scope.
`ifndef PRIORITY_RR_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_RR_TASK_SCHEDULER_DEFINES_SVH
// Same-cycle implication checked on every clock edge outside reset.
`define PRTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define PRTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/prts_pkg.sv]
// Shared types and constants of the two-core task scheduler.
// No dependencies.
package prts_pkg;
  localparam int unsigned TableSlots = 16;
  localparam int unsigned PrioLevels = 16;
  localparam int unsigned SlotW = $clog2(TableSlots);
  localparam int unsigned PrioW = 4;

  localparam logic [2:0] ReqCreate = 3'd0;
  localparam logic [2:0] ReqTick = 3'd1;
  localparam logic [2:0] ReqRunStart = 3'd2;
  localparam logic [2:0] ReqRunDone = 3'd3;
  localparam logic [2:0] ReqYield = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNoTask = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StBadAff = 3'd3;
  localparam logic [2:0] StDisabled = 3'd4;

  localparam logic [1:0] EsInactive = 2'd0;
  localparam logic [1:0] EsReady = 2'd1;
  localparam logic [1:0] EsRunning = 2'd2;
  localparam logic [1:0] EsCompleted = 2'd3;

  localparam logic [1:0] AffAny = 2'd2;
  localparam logic [1:0] AffBad = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CREATE, S_PRIO, S_ROT, S_PICKED, S_EMIT, S_WAIT
  } ctrl_state_e;

  // Commands from the controller.
  typedef struct packed {
    logic latch_req;   // capture the input beat
    logic do_create;   // run the create step
    logic clr_scan;    // start a scan pass
    logic scan_prio;   // one step of the priority pass
    logic scan_rot;    // one step of the rotation pass
    logic do_finish;   // apply the request result
    logic load_out;    // put result in output register
    logic next_core;   // advance tick to core 1
  } cmd_t;

  // Status to the controller.
  typedef struct packed {
    logic scan_done;   // the current pass has visited every slot, or the rotation pass has found its pick
    logic need_pick;   // the request needs a pick
    logic is_tick;
    logic tick_core;   // tick is on core 1
    logic no_result;   // unknown request
  } sts_t;
endpackage

[sv/prts_ctrl.sv]
// Sequencer of the scheduler: steps create, priority and rotation passes.
// Depends on prts_pkg.
module prts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_busy_i,
  input  prts_pkg::sts_t   sts_i,
  output prts_pkg::cmd_t   cmd_o
);
  prts_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prts_pkg::S_IDLE: if (in_valid_i) state_d = prts_pkg::S_DECODE;
      prts_pkg::S_DECODE: begin
        if (sts_i.no_result) state_d = prts_pkg::S_IDLE;
        else if (sts_i.need_pick) state_d = prts_pkg::S_PRIO;
        else state_d = prts_pkg::S_CREATE;
      end
      prts_pkg::S_CREATE: state_d = prts_pkg::S_EMIT;
      prts_pkg::S_PRIO: if (sts_i.scan_done) state_d = prts_pkg::S_ROT;
      prts_pkg::S_ROT: if (sts_i.scan_done) state_d = prts_pkg::S_PICKED;
      prts_pkg::S_PICKED: state_d = prts_pkg::S_EMIT;
      prts_pkg::S_EMIT: if (!out_busy_i) begin
        if (sts_i.is_tick && sts_i.need_pick && !sts_i.tick_core) state_d = prts_pkg::S_WAIT;
        else state_d = prts_pkg::S_IDLE;
      end
      prts_pkg::S_WAIT: state_d = prts_pkg::S_PRIO;
      default: state_d = prts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      prts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.latch_req = in_valid_i;
      end
      prts_pkg::S_DECODE: cmd_o.clr_scan = 1'b1;
      prts_pkg::S_CREATE: cmd_o.do_create = 1'b1;
      prts_pkg::S_PRIO: begin
        cmd_o.scan_prio = 1'b1;
        cmd_o.clr_scan = sts_i.scan_done;
      end
      prts_pkg::S_ROT: cmd_o.scan_rot = 1'b1;
      prts_pkg::S_PICKED: cmd_o.do_finish = 1'b1;
      prts_pkg::S_EMIT: cmd_o.load_out = !out_busy_i;
      prts_pkg::S_WAIT: begin
        cmd_o.next_core = 1'b1;
        cmd_o.clr_scan = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end
endmodule

[sv/prts_dp.sv]
// Datapath of the scheduler: task tables, current-task registers, scan
// unit and result registers. Depends on prts_pkg.
module prts_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_en_i,
  input  logic [2:0]             req_type_i,
  input  logic                   core_sel_i,
  input  logic [3:0]             task_priority_i,
  input  logic [1:0]             affinity_i,
  input  logic                   persistent_i,
  input  prts_pkg::cmd_t         cmd_i,
  output prts_pkg::sts_t         sts_o,
  output logic                   res_valid_o,
  output logic [2:0]             res_status_o,
  output logic                   res_core_o,
  output logic [31:0]            res_ident_o,
  output logic [3:0]             res_slot_o,
  output logic                   res_switched_o,
  output logic                   res_last_o
);
  localparam int unsigned N = prts_pkg::TableSlots;
  localparam int unsigned SW = prts_pkg::SlotW;
  localparam int unsigned PW = prts_pkg::PrioW;
  localparam logic [PW-1:0] PrioMax = PW'(prts_pkg::PrioLevels - 1);

  // Per-slot flip-flops, each read at its own place or by the scan index.
  logic [1:0]    est_q  [2][N];
  logic [PW-1:0] epri_q [2][N];
  logic [1:0]    eaff_q [2][N];
  logic          epers_q[2][N];
  logic [31:0]   eid_q  [2][N];

  logic          cur_v_q[2];
  logic [SW-1:0] cur_s_q[2];
  logic [SW-1:0] rot_q  [2];
  logic [31:0]   nid_q;

  logic [2:0]    req_q;
  logic          csel_q, pers_q;
  logic [PW-1:0] prio_q;
  logic [1:0]    aff_q;
  logic          en_q;   // enable sampled with the beat
  logic          core_q; // core being worked on

  logic [SW:0]   cnt_q;
  logic          found_q;
  logic [PW-1:0] best_q;
  logic [SW-1:0] pick_q;
  logic          pfound_q;

  logic [SW-1:0] idx, rd;
  logic          elig;
  logic [1:0]    tgt;

  // First inactive slot of the create target, a small priority encoder.
  logic          free_v;
  logic [SW-1:0] free_s;
  logic          tcore;

  assign tcore = (aff_q == prts_pkg::AffAny) ? 1'b0 : aff_q[0];
  always_comb begin
    free_v = 1'b0;
    free_s = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (est_q[tcore][i] == prts_pkg::EsInactive) begin
        free_v = 1'b1;
        free_s = SW'(i);
      end
    end
  end

  assign idx = cnt_q[SW-1:0];
  assign rd = rot_q[core_q] + SW'(1) + idx;
  assign tgt = {1'b0, core_q};

  logic [SW-1:0] sidx;
  assign sidx = cmd_i.scan_rot ? rd : idx;
  assign elig = (est_q[core_q][sidx] == prts_pkg::EsReady) &&
                (eaff_q[core_q][sidx] == tgt || eaff_q[core_q][sidx] == prts_pkg::AffAny);

  assign sts_o.scan_done = cnt_q[SW] || (cmd_i.scan_rot && pfound_q);
  assign sts_o.is_tick = (req_q == prts_pkg::ReqTick);
  assign sts_o.tick_core = core_q;
  assign sts_o.no_result = (req_q > prts_pkg::ReqYield);

  // Current task of the requested core.
  logic [SW-1:0] cur_sl;
  logic [1:0]    cur_est;
  logic [31:0]   cur_id;
  assign cur_sl = cur_s_q[csel_q];
  assign cur_est = est_q[csel_q][cur_sl];
  assign cur_id = eid_q[csel_q][cur_sl];

  // Requests that need the scan: enabled tick, enabled run-start without
  // a ready current task.
  logic cur_ready;
  assign cur_ready = cur_v_q[csel_q] && cur_est == prts_pkg::EsReady;
  assign sts_o.need_pick = en_q && ((req_q == prts_pkg::ReqTick) ||
                           (req_q == prts_pkg::ReqRunStart && !cur_ready));

  // Core whose running persistent task a tick returns to ready; core 1 is
  // handled while the tick moves on to it.
  logic rr_core;
  assign rr_core = core_q | cmd_i.next_core;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < N; i++) est_q[c][i] <= prts_pkg::EsInactive;
        cur_v_q[c] <= 1'b0;
        cur_s_q[c] <= '0;
        rot_q[c] <= '0;
      end
      nid_q <= 32'd1;
      res_valid_o <= 1'b0;
      req_q <= '0;
      en_q <= 1'b0;
      core_q <= 1'b0;
      cnt_q <= '0;
      found_q <= 1'b0;
      pfound_q <= 1'b0;
    end else begin
      if (cmd_i.latch_req) begin
        req_q <= req_type_i;
        en_q <= cfg_en_i;
        core_q <= (req_type_i == prts_pkg::ReqTick) ? 1'b0 : core_sel_i;
      end
      if (cmd_i.clr_scan) begin
        cnt_q <= '0;
        if (!cmd_i.scan_prio) found_q <= 1'b0;
        pfound_q <= 1'b0;
        // Tick first returns a running persistent current task to ready.
        if (req_q == prts_pkg::ReqTick && en_q && !cmd_i.scan_prio && cur_v_q[rr_core] &&
            est_q[rr_core][cur_s_q[rr_core]] == prts_pkg::EsRunning &&
            epers_q[rr_core][cur_s_q[rr_core]])
          est_q[rr_core][cur_s_q[rr_core]] <= prts_pkg::EsReady;
      end
      if (cmd_i.scan_prio && !cnt_q[SW]) begin
        cnt_q <= cnt_q + 1'b1;
        if (elig && (!found_q || epri_q[core_q][idx] > best_q)) begin
          found_q <= 1'b1;
          best_q <= epri_q[core_q][idx];
        end
      end
      if (cmd_i.scan_rot && !sts_o.scan_done) begin
        cnt_q <= cnt_q + 1'b1;
        if (found_q && elig && epri_q[core_q][rd] == best_q) begin
          pfound_q <= 1'b1;
          pick_q <= rd;
        end
      end
      if (cmd_i.do_finish && pfound_q) begin
        rot_q[core_q] <= pick_q;
      end
      if (cmd_i.next_core) core_q <= 1'b1;
      if (cmd_i.do_create && req_q == prts_pkg::ReqCreate) begin
        res_switched_o <= 1'b0;
        if (aff_q == prts_pkg::AffBad) begin
          res_status_o <= prts_pkg::StBadAff;
          res_core_o <= 1'b0;
          res_ident_o <= 32'd0;
          res_slot_o <= '0;
        end else if (!free_v) begin
          res_status_o <= prts_pkg::StFull;
          res_core_o <= tcore;
          res_ident_o <= 32'd0;
          res_slot_o <= '0;
        end else begin
          est_q[tcore][free_s] <= prts_pkg::EsReady;
          epri_q[tcore][free_s] <= prio_q > PrioMax ? PrioMax : prio_q;
          eaff_q[tcore][free_s] <= aff_q;
          epers_q[tcore][free_s] <= pers_q;
          eid_q[tcore][free_s] <= nid_q;
          nid_q <= nid_q + 32'd1;
          res_status_o <= prts_pkg::StOk;
          res_core_o <= tcore;
          res_ident_o <= nid_q;
          res_slot_o <= 4'(free_s);
        end
      end
      if (cmd_i.do_finish) begin
        res_core_o <= core_q;
        if (!pfound_q) begin
          res_status_o <= prts_pkg::StNoTask;
          res_ident_o <= 32'd0;
          res_slot_o <= '0;
          res_switched_o <= 1'b0;
          if (req_q == prts_pkg::ReqRunStart) cur_v_q[core_q] <= 1'b0;
        end else begin
          res_status_o <= prts_pkg::StOk;
          res_ident_o <= eid_q[core_q][pick_q];
          res_slot_o <= 4'(pick_q);
          cur_v_q[core_q] <= 1'b1;
          cur_s_q[core_q] <= pick_q;
          if (req_q == prts_pkg::ReqTick) begin
            res_switched_o <= !cur_v_q[core_q] || cur_s_q[core_q] != pick_q;
          end else begin
            res_switched_o <= 1'b0;
            est_q[core_q][pick_q] <= prts_pkg::EsRunning;
          end
        end
      end
      // Non-scanning requests other than create resolve in the decode cycle.
      if (cmd_i.clr_scan && !cmd_i.scan_prio && !cmd_i.next_core &&
          !sts_o.need_pick && req_q != prts_pkg::ReqCreate && !sts_o.no_result) begin
        res_core_o <= (req_q == prts_pkg::ReqTick) ? 1'b0 : csel_q;
        res_switched_o <= 1'b0;
        unique case (req_q)
          prts_pkg::ReqTick: begin
            res_status_o <= prts_pkg::StDisabled;
            res_ident_o <= 32'd0;
            res_slot_o <= '0;
          end
          prts_pkg::ReqRunStart: begin
            if (!en_q) begin
              res_status_o <= prts_pkg::StDisabled;
              res_ident_o <= 32'd0;
              res_slot_o <= '0;
            end else begin
              est_q[csel_q][cur_sl] <= prts_pkg::EsRunning;
              res_status_o <= prts_pkg::StOk;
              res_ident_o <= cur_id;
              res_slot_o <= 4'(cur_sl);
            end
          end
          prts_pkg::ReqRunDone: begin
            if (cur_v_q[csel_q] && cur_est == prts_pkg::EsRunning) begin
              if (epers_q[csel_q][cur_sl]) begin
                est_q[csel_q][cur_sl] <= prts_pkg::EsReady;
              end else begin
                est_q[csel_q][cur_sl] <= prts_pkg::EsCompleted;
                cur_v_q[csel_q] <= 1'b0;
              end
              res_status_o <= prts_pkg::StOk;
              res_ident_o <= cur_id;
              res_slot_o <= 4'(cur_sl);
            end else begin
              res_status_o <= prts_pkg::StNoTask;
              res_ident_o <= 32'd0;
              res_slot_o <= '0;
            end
          end
          prts_pkg::ReqYield: begin
            if (cur_v_q[csel_q]) begin
              est_q[csel_q][cur_sl] <= prts_pkg::EsReady;
              res_status_o <= prts_pkg::StOk;
              res_ident_o <= cur_id;
              res_slot_o <= 4'(cur_sl);
            end else begin
              res_status_o <= prts_pkg::StNoTask;
              res_ident_o <= 32'd0;
              res_slot_o <= '0;
            end
          end
          default: begin
            res_status_o <= prts_pkg::StNoTask;
            res_ident_o <= 32'd0;
            res_slot_o <= '0;
          end
        endcase
      end
      if (cmd_i.load_out) begin
        res_valid_o <= 1'b1;
        res_last_o <= !(req_q == prts_pkg::ReqTick && en_q && !core_q);
      end else begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      csel_q <= core_sel_i;
      prio_q <= task_priority_i;
      aff_q <= affinity_i;
      pers_q <= persistent_i;
    end
  end
endmodule

[sv/prts_out.sv]
// Output register stage holding one result beat until it is taken.
// Depends on prts_pkg.
module prts_out (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [2:0]  status_i,
  input  logic        core_i,
  input  logic [31:0] ident_i,
  input  logic [3:0]  slot_i,
  input  logic        switched_i,
  input  logic        last_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        core_out_o,
  output logic [31:0] task_ident_o,
  output logic [3:0]  slot_out_o,
  output logic        switched_o,
  output logic        last_o
);
  logic valid_q;
  assign busy_o = valid_q && !out_ready_i;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_o <= status_i;
      core_out_o <= core_i;
      task_ident_o <= ident_i;
      slot_out_o <= slot_i;
      switched_o <= switched_i;
      last_o <= last_i;
    end
  end
endmodule

[sv/priority_rr_task_scheduler.sv]
// Two-core priority round-robin task scheduler, top level.
// Depends on prts_pkg, prts_ctrl, prts_dp and prts_out.
// One request at a time. A tick or a run-start that must pick scans the
// core's 16-slot table twice (priority pass, then a rotation pass that
// stops at its pick); an enabled tick does so for core 0, then core 1.
// The scan runs one slot per cycle. Results leave through a one-beat
// output register.
module priority_rr_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic        core_sel_i,
  input  logic [3:0]  task_priority_i,
  input  logic [1:0]  affinity_i,
  input  logic        persistent_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        core_out_o,
  output logic [31:0] task_ident_o,
  output logic [3:0]  slot_out_o,
  output logic        switched_o,
  output logic        last_o
);
  logic enable_q;
  prts_pkg::cmd_t cmd;
  prts_pkg::sts_t sts;
  logic busy, rv, rc, rsw, rl;
  logic [2:0] rs;
  logic [31:0] rid;
  logic [3:0] rsl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  prts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i(busy), .sts_i(sts), .cmd_o(cmd)
  );

  prts_dp u_dp (
    .clk_i, .rst_ni, .cfg_en_i(enable_q),
    .req_type_i, .core_sel_i, .task_priority_i, .affinity_i, .persistent_i,
    .cmd_i(cmd), .sts_o(sts), .res_valid_o(rv),
    .res_status_o(rs), .res_core_o(rc), .res_ident_o(rid),
    .res_slot_o(rsl), .res_switched_o(rsw), .res_last_o(rl)
  );

  // load_q is res_valid_o registered, so the output stage loads only on its rising edge.
  logic load_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) load_q <= 1'b0;
    else load_q <= rv;
  end

  prts_out u_out (
    .clk_i, .rst_ni, .load_i(rv && !load_q),
    .status_i(rs), .core_i(rc), .ident_i(rid), .slot_i(rsl),
    .switched_i(rsw), .last_i(rl), .busy_o(busy),
    .out_valid_o, .out_ready_i, .status_o, .core_out_o, .task_ident_o,
    .slot_out_o, .switched_o, .last_o
  );
endmodule

[sv/prts_checker.sv]
// Port-level checker of the task scheduler, bound to the top level.
// Depends on prts_pkg and priority_rr_task_scheduler_defines.svh.
`include "priority_rr_task_scheduler_defines.svh"
module prts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] task_ident_o,
  input logic        switched_o,
  input logic        last_o
);
  logic in_acc, out_stall, res_fail, res_sw, res_dis;
  assign in_acc = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign res_fail = out_valid_o && status_o != prts_pkg::StOk;
  assign res_sw = out_valid_o && switched_o;
  assign res_dis = out_valid_o && status_o == prts_pkg::StDisabled;

  `PRTS_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(task_ident_o), "beat dropped")
  `PRTS_ASSERT_IMP(a_notask_zero, res_fail, task_ident_o == 32'd0, "id on failed result")
  `PRTS_ASSERT_IMP(a_sw_ok, res_sw, status_o == prts_pkg::StOk, "switch without task")
  `PRTS_ASSERT_NXT(a_one_at_time, in_acc, !in_ready_o, "second beat taken")
  `PRTS_ASSERT_IMP(a_dis_last, res_dis, last_o, "disabled answer not last")
endmodule

bind priority_rr_task_scheduler prts_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .task_ident_o, .switched_o, .last_o
);
